/* hdl/bdra_pkg.sv */
// Shared types and constants for the bounded-denominator rational approximation unit.
package bdra_pkg;

  localparam int VAL_W = 64;
  localparam int LIM_W = 20;
  localparam logic [LIM_W-1:0] LIM_RESET = 20'hFFFFF;

  typedef struct packed {
    logic [VAL_W-1:0] numerator;
    logic [VAL_W-1:0] denominator;
  } in_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] approx_numerator;
    logic [VAL_W-1:0] approx_denominator;
    logic             invalid_input;
  } out_beat_t;

endpackage

/* hdl/bdra_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module bdra_div import bdra_pkg::*; #(
  parameter int W = VAL_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       trial;
  logic             fits;

  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? W'(trial - {1'b0, dsr_r}) : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* hdl/bdra_mul.sv */
// Iterative shift-add multiplier, full double-width product.
module bdra_mul import bdra_pkg::*; #(
  parameter int W = VAL_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           done,
  output logic [2*W-1:0] product
);

  localparam int CNT_W = $clog2(W + 1);

  logic [2*W-1:0]   prod_r, prod_nxt;
  logic [W-1:0]     mcd_r, mcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       upper;

  assign upper = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, mcd_r} : '0);

  always_comb begin
    prod_nxt = prod_r;
    mcd_nxt  = mcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      prod_nxt = {{W{1'b0}}, mplier};
      mcd_nxt  = mcand;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {upper, prod_r[W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    mcd_r  <= mcd_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

/* hdl/bounded_denominator_rational_approx_unit.sv */
// Top level: sequencer for the gcd reduction and continued-fraction search.
// A zero numerator or denominator goes straight to the output; otherwise each gcd step is
//   one divide, the reduction two divides, and each cf step one divide and two multiplies;
//   at 64 bits the worst case is ~92 gcd and ~30 cf steps.
// Throughput: one item at a time; in_stall is high from accept until the result beat is
//   loaded into the output register. Sync active-low reset: control idle, limit 1048575.
module bounded_denominator_rational_approx_unit import bdra_pkg::*; #(
  parameter int VALUE_WIDTH = VAL_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = (W > LIM_W) ? W : LIM_W;   // width for limit compares

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_GCD_CHK  = 4'd1;
  localparam logic [3:0] ST_GCD_WAIT = 4'd2;
  localparam logic [3:0] ST_RED_P    = 4'd3;
  localparam logic [3:0] ST_RED_Q    = 4'd4;
  localparam logic [3:0] ST_CF_CHK   = 4'd5;
  localparam logic [3:0] ST_CF_DIV   = 4'd6;
  localparam logic [3:0] ST_CF_MH    = 4'd7;
  localparam logic [3:0] ST_CF_MK    = 4'd8;
  localparam logic [3:0] ST_T_DIV    = 4'd9;
  localparam logic [3:0] ST_S_MH     = 4'd10;
  localparam logic [3:0] ST_S_MK     = 4'd11;
  localparam logic [3:0] ST_S_ME     = 4'd12;
  localparam logic [3:0] ST_S_P1     = 4'd13;
  localparam logic [3:0] ST_S_P2     = 4'd14;
  localparam logic [3:0] ST_OUT      = 4'd15;

  logic [3:0]       state_r, state_nxt;
  logic [LIM_W-1:0] lim_r;

  // x/y: Euclid pair during gcd, then the remainders of the two last convergents
  logic [W-1:0]   x_r, x_nxt, y_r, y_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [W-1:0]   hm1_r, hm1_nxt, hm2_r, hm2_nxt, km1_r, km1_nxt, km2_r, km2_nxt;
  logic [W-1:0]   aq_r, aq_nxt, rr_r, rr_nxt, h_r, h_nxt, t_r, t_nxt;
  logic [W-1:0]   sh_r, sh_nxt, sk_r, sk_nxt;
  logic [2*W-1:0] p1_r, p1_nxt;
  logic [W-1:0]   res_n_r, res_n_nxt, res_d_r, res_d_nxt;
  logic           res_inv_r, res_inv_nxt;
  out_beat_t      out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // shared unit operands and start pulses
  logic [W-1:0] div_a_r, div_a_nxt, div_b_r, div_b_nxt;
  logic [W-1:0] mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic         div_go_r, div_go_nxt, mul_go_r, mul_go_nxt;

  logic           div_done, mul_done;
  logic [W-1:0]   div_quo, div_rem;
  logic [2*W-1:0] mul_prod;
  logic [W-1:0]   mul_lo;
  logic [W-1:0]   in_p, in_q;
  logic [CW-1:0]  lim_eff;
  logic [W-1:0]   k_sum;

  bdra_div #(.W(W)) u_div (
    .clk, .rst_n, .go(div_go_r), .dividend(div_a_r), .divisor(div_b_r),
    .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  bdra_mul #(.W(W)) u_mul (
    .clk, .rst_n, .go(mul_go_r), .mcand(mul_a_r), .mplier(mul_b_r),
    .done(mul_done), .product(mul_prod)
  );

  assign in_p    = in_data.numerator[W-1:0];
  assign in_q    = in_data.denominator[W-1:0];
  // a zero limit behaves as a limit of one
  assign lim_eff = (lim_r == '0) ? CW'(1) : CW'(lim_r);
  assign mul_lo  = mul_prod[W-1:0];
  assign k_sum   = mul_lo + km2_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;  y_nxt = y_r;  p_nxt = p_r;  q_nxt = q_r;
    hm1_nxt = hm1_r;  hm2_nxt = hm2_r;  km1_nxt = km1_r;  km2_nxt = km2_r;
    aq_nxt = aq_r;  rr_nxt = rr_r;  h_nxt = h_r;  t_nxt = t_r;
    sh_nxt = sh_r;  sk_nxt = sk_r;  p1_nxt = p1_r;
    res_n_nxt = res_n_r;  res_d_nxt = res_d_r;  res_inv_nxt = res_inv_r;
    div_a_nxt = div_a_r;  div_b_nxt = div_b_r;
    mul_a_nxt = mul_a_r;  mul_b_nxt = mul_b_r;
    div_go_nxt = 1'b0;
    mul_go_nxt = 1'b0;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_q == '0) begin
            // invalid: echo the input
            res_n_nxt = in_p;  res_d_nxt = '0;  res_inv_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else if (in_p == '0) begin
            res_n_nxt = '0;  res_d_nxt = W'(1);  res_inv_nxt = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            x_nxt = in_p;  y_nxt = in_q;  p_nxt = in_p;  q_nxt = in_q;
            res_inv_nxt = 1'b0;
            state_nxt = ST_GCD_CHK;
          end
        end
      end
      ST_GCD_CHK: begin
        div_go_nxt = 1'b1;
        if (y_r == '0) begin
          div_a_nxt = p_r;  div_b_nxt = x_r;       // x holds the gcd
          state_nxt = ST_RED_P;
        end else begin
          div_a_nxt = x_r;  div_b_nxt = y_r;
          state_nxt = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_done) begin
          x_nxt = y_r;  y_nxt = div_rem;
          state_nxt = ST_GCD_CHK;
        end
      end
      ST_RED_P: begin
        if (div_done) begin
          p_nxt = div_quo;
          div_a_nxt = q_r;  div_b_nxt = x_r;  div_go_nxt = 1'b1;
          state_nxt = ST_RED_Q;
        end
      end
      ST_RED_Q: begin
        if (div_done) begin
          q_nxt = div_quo;
          if (CW'(div_quo) <= lim_eff) begin
            res_n_nxt = p_r;  res_d_nxt = div_quo;
            state_nxt = ST_OUT;
          end else begin
            x_nxt = p_r;  y_nxt = div_quo;
            hm2_nxt = '0;  hm1_nxt = W'(1);  km2_nxt = W'(1);  km1_nxt = '0;
            state_nxt = ST_CF_CHK;
          end
        end
      end
      ST_CF_CHK: begin
        if (y_r == '0) begin
          res_n_nxt = hm1_r;  res_d_nxt = km1_r;
          state_nxt = ST_OUT;
        end else begin
          div_a_nxt = x_r;  div_b_nxt = y_r;  div_go_nxt = 1'b1;
          state_nxt = ST_CF_DIV;
        end
      end
      ST_CF_DIV: begin
        if (div_done) begin
          aq_nxt = div_quo;  rr_nxt = div_rem;
          mul_a_nxt = div_quo;  mul_b_nxt = hm1_r;  mul_go_nxt = 1'b1;
          state_nxt = ST_CF_MH;
        end
      end
      ST_CF_MH: begin
        if (mul_done) begin
          h_nxt = mul_lo + hm2_r;
          mul_a_nxt = aq_r;  mul_b_nxt = km1_r;  mul_go_nxt = 1'b1;
          state_nxt = ST_CF_MK;
        end
      end
      ST_CF_MK: begin
        if (mul_done) begin
          if (CW'(k_sum) > lim_eff) begin
            if (km1_r == '0) begin
              res_n_nxt = hm1_r;  res_d_nxt = W'(1);
              state_nxt = ST_OUT;
            end else begin
              // largest semiconvergent index t = (lim - km2) / km1
              div_a_nxt = W'(lim_eff - CW'(km2_r));
              div_b_nxt = km1_r;  div_go_nxt = 1'b1;
              state_nxt = ST_T_DIV;
            end
          end else begin
            hm2_nxt = hm1_r;  hm1_nxt = h_r;
            km2_nxt = km1_r;  km1_nxt = k_sum;
            x_nxt = y_r;  y_nxt = rr_r;
            state_nxt = ST_CF_CHK;
          end
        end
      end
      ST_T_DIV: begin
        if (div_done) begin
          t_nxt = div_quo;
          if (div_quo == '0) begin
            res_n_nxt = hm1_r;  res_d_nxt = km1_r;
            state_nxt = ST_OUT;
          end else begin
            mul_a_nxt = div_quo;  mul_b_nxt = hm1_r;  mul_go_nxt = 1'b1;
            state_nxt = ST_S_MH;
          end
        end
      end
      ST_S_MH: begin
        if (mul_done) begin
          sh_nxt = mul_lo + hm2_r;
          mul_a_nxt = t_r;  mul_b_nxt = km1_r;  mul_go_nxt = 1'b1;
          state_nxt = ST_S_MK;
        end
      end
      ST_S_MK: begin
        if (mul_done) begin
          sk_nxt = k_sum;
          mul_a_nxt = t_r;  mul_b_nxt = y_r;  mul_go_nxt = 1'b1;
          state_nxt = ST_S_ME;
        end
      end
      ST_S_ME: begin
        if (mul_done) begin
          // semiconvergent error term, times km1
          mul_a_nxt = x_r - mul_lo;  mul_b_nxt = km1_r;  mul_go_nxt = 1'b1;
          state_nxt = ST_S_P1;
        end
      end
      ST_S_P1: begin
        if (mul_done) begin
          p1_nxt = mul_prod;
          mul_a_nxt = y_r;  mul_b_nxt = sk_r;  mul_go_nxt = 1'b1;
          state_nxt = ST_S_P2;
        end
      end
      ST_S_P2: begin
        if (mul_done) begin
          // strictly closer semiconvergent wins; a tie keeps the convergent
          if (p1_r < mul_prod) begin
            res_n_nxt = sh_r;  res_d_nxt = sk_r;
          end else begin
            res_n_nxt = hm1_r;  res_d_nxt = km1_r;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.approx_numerator   = VAL_W'(res_n_r);
          out_nxt.approx_denominator = VAL_W'(res_d_r);
          out_nxt.invalid_input      = res_inv_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;  y_r <= y_nxt;  p_r <= p_nxt;  q_r <= q_nxt;
    hm1_r <= hm1_nxt;  hm2_r <= hm2_nxt;  km1_r <= km1_nxt;  km2_r <= km2_nxt;
    aq_r <= aq_nxt;  rr_r <= rr_nxt;  h_r <= h_nxt;  t_r <= t_nxt;
    sh_r <= sh_nxt;  sk_r <= sk_nxt;  p1_r <= p1_nxt;
    res_n_r <= res_n_nxt;  res_d_r <= res_d_nxt;  res_inv_r <= res_inv_nxt;
    div_a_r <= div_a_nxt;  div_b_r <= div_b_nxt;
    mul_a_r <= mul_a_nxt;  mul_b_r <= mul_b_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lim_r       <= LIM_RESET;
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_go_r    <= div_go_nxt;
      mul_go_r    <= mul_go_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* test/tb_bounded_denominator_rational_approx_unit.sv */
// Testbench for the bounded-denominator rational approximation unit.
module tb_bounded_denominator_rational_approx_unit;
  import bdra_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  bounded_denominator_rational_approx_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Testbench copy of the limit register.
  logic [LIM_W-1:0] model_limit;

  in_beat_t  pending_fracs[$];
  out_beat_t expected_approx[$];
  int        mismatches;
  int        long_hold;   // receiver hold-off request, in cycles
  bit        pause_sender;

  // Exact 128-bit product compare: a*b < c*d.
  function automatic bit prod_lt(logic [63:0] a, logic [63:0] b,
                                 logic [63:0] c, logic [63:0] d);
    logic [127:0] x;
    logic [127:0] y;
    x = {64'd0, a} * {64'd0, b};
    y = {64'd0, c} * {64'd0, d};
    return x < y;
  endfunction

  function automatic out_beat_t best_rational(in_beat_t frac, logic [LIM_W-1:0] lim_reg);
    out_beat_t   res;
    logic [63:0] p, q, g, x, y, r, lim;
    logic [63:0] hm2, hm1, km2, km1, ar, br, a, h, k, t, sh, sk, serr;
    bit          done;
    p = frac.numerator;
    q = frac.denominator;
    lim = (lim_reg == '0) ? 64'd1 : {44'd0, lim_reg};
    res = '0;
    done = 0;
    if (q == 0) begin
      res.approx_numerator = p;
      res.invalid_input = 1'b1;
      return res;
    end
    if (p == 0) begin
      res.approx_denominator = 64'd1;
      return res;
    end
    x = p; y = q;
    while (y != 0) begin
      r = x % y; x = y; y = r;
    end
    g = x;
    p = p / g; q = q / g;
    if (q <= lim) begin
      res.approx_numerator = p;
      res.approx_denominator = q;
      return res;
    end
    hm2 = 0; hm1 = 1; km2 = 1; km1 = 0;
    ar = p; br = q;
    while (br != 0 && !done) begin
      a = ar / br;
      r = ar % br;
      h = a * hm1 + hm2;
      k = a * km1 + km2;
      if (k > lim) begin
        done = 1;
        if (km1 == 0) begin
          res.approx_numerator = hm1;
          res.approx_denominator = 64'd1;
        end else begin
          t = (lim - km2) / km1;
          if (t == 0) begin
            res.approx_numerator = hm1;
            res.approx_denominator = km1;
          end else begin
            sh = t * hm1 + hm2;
            sk = t * km1 + km2;
            serr = ar - t * br;
            if (prod_lt(serr, km1, br, sk)) begin
              res.approx_numerator = sh;
              res.approx_denominator = sk;
            end else begin
              res.approx_numerator = hm1;
              res.approx_denominator = km1;
            end
          end
        end
      end else begin
        hm2 = hm1; hm1 = h; km2 = km1; km1 = k;
        ar = br; br = r;
      end
    end
    if (!done) begin
      res.approx_numerator = hm1;
      res.approx_denominator = km1;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly small-to-mid values so reductions and convergent walks vary.
  function automatic logic [63:0] rand_val();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return rand64() >> $urandom_range(0, 63);
      2: return 64'($urandom_range(0, 1000));
      3: return 64'($urandom);
      4: return ~(64'($urandom_range(0, 3)));
      default: return 64'($urandom_range(0, 3000000));
    endcase
  endfunction

  task automatic push_frac(logic [63:0] p, logic [63:0] q);
    in_beat_t b;
    b.numerator = p;
    b.denominator = q;
    pending_fracs.push_back(b);
  endtask

  // Driver: one beat at a time, random gap before each, payload held while stalled.
  int in_gap;
  int in_draw;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_stall) begin
      // Beat accepted: predict from the limit in force now.
      expected_approx.push_back(best_rational(in_data, model_limit));
      in_draw = $urandom_range(0, 5);
      in_gap <= in_draw;
      if (in_draw == 0 && pending_fracs.size() != 0 && !pause_sender) begin
        in_data <= pending_fracs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_fracs.size() != 0 && !pause_sender) begin
        in_data <= pending_fracs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: random stall per beat, plus the long hold-off when requested.
  int out_gap;
  int out_draw;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      out_draw = out_gap;
      if (out_valid && !out_stall) begin
        if (expected_approx.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: %h", out_data);
        end else begin
          out_beat_t e;
          e = expected_approx.pop_front();
          if (e.approx_numerator !== out_data.approx_numerator ||
              e.approx_denominator !== out_data.approx_denominator ||
              e.invalid_input !== out_data.invalid_input) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d inv=%0d, got %0d/%0d inv=%0d",
                       e.approx_numerator, e.approx_denominator, e.invalid_input,
                       out_data.approx_numerator, out_data.approx_denominator,
                       out_data.invalid_input);
          end
        end
        out_draw = $urandom_range(0, 5);
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_gap <= out_draw;
        out_stall <= 1'b1;
      end else if (out_draw > 0) begin
        out_gap <= out_draw - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Wait until every queued beat was sent and every result has come back.
  task automatic drain();
    while (pending_fracs.size() != 0 || in_valid || expected_approx.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_limit = v;
  endtask

  task automatic random_batch(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        push_frac(rand_val(), 64'd0);
      else if ($urandom_range(0, 9) == 0)
        push_frac(64'd0, rand_val());
      else if ($urandom_range(0, 3) == 0) begin
        // Common factor to exercise the gcd reduction.
        logic [63:0] f;
        f = 64'($urandom_range(1, 100000));
        push_frac(64'($urandom) * f, 64'($urandom) * f);
      end else
        push_frac(rand_val(), rand_val());
    end
  endtask

  initial begin
    logic [LIM_W-1:0] limits[6];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    mismatches = 0;
    long_hold <= 0;
    pause_sender = 0;
    model_limit = LIM_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limit, edges of both fields, invalid and zero cases.
    push_frac(64'd0, 64'd0);
    push_frac('1, 64'd0);
    push_frac(64'd0, '1);
    push_frac('1, '1);
    push_frac('1, 64'd1);
    push_frac(64'd1, '1);
    push_frac(64'd6, 64'd4);
    push_frac(64'd355, 64'd113);
    push_frac(64'd314159265358979, 64'd100000000000000);
    push_frac(64'd1, 64'd1048576);
    push_frac(64'd1, 64'd2097151);
    push_frac(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    push_frac(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
    drain();

    // Zero limit acts as one; also a tie-prone small limit of two.
    write_limit('0);
    push_frac(64'd7, 64'd2);
    push_frac(64'd1, 64'd3);
    push_frac(64'd5, 64'd2);
    push_frac(64'd3, 64'd2);
    drain();
    write_limit(20'd2);
    push_frac(64'd3, 64'd4);
    push_frac(64'd1, 64'd4);
    push_frac(64'd5, 64'd8);
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    write_limit(20'd1000);
    long_hold <= 400;
    random_batch(10);
    drain();

    // Random phases over several limits, extremes included.
    limits = '{20'd1, 20'd7, 20'd113, 20'd65535, 20'hFFFFF, 20'd0};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      random_batch(15);
      // Sender pauses mid-phase until all results are in.
      pause_sender = 1;
      while (in_valid || expected_approx.size() != 0) @(posedge clk);
      pause_sender = 0;
      random_batch(15);
      drain();
    end
    write_limit(20'($urandom));
    random_batch(10);
    drain();

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #200000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hdl/bdra_pkg.sv
hdl/bdra_div.sv
hdl/bdra_mul.sv
hdl/bounded_denominator_rational_approx_unit.sv
test/tb_bounded_denominator_rational_approx_unit.sv
